>>> hdl/rotary_position_embedding_core_macros.svh
// Assertion macros for the rotary position embedding core.
// No dependencies; included by files that carry concurrent checks.
`ifndef ROTARY_POSITION_EMBEDDING_CORE_MACROS_SVH
`define ROTARY_POSITION_EMBEDDING_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/rpe_pkg.sv
// Shared types and constants for the rotary position embedding core.
// No dependencies.
package rpe_pkg;

    localparam int INDEX_W    = 6;
    localparam int POS_W      = 16;
    localparam int FREQ_W     = 32;
    localparam int ATAN_STEPS = 24;
    localparam int XY_W       = 34;   // Q1.30 cos/sin plus headroom
    localparam int Z_W        = 33;   // residual angle, Q0.32 turns, signed

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0]     HALF_Q30 = 32'sd536870912;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // arctangent of 2^-i in Q0.32 turns
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            5'd20:   v = 33'sd652;
            5'd21:   v = 33'sd326;
            5'd22:   v = 33'sd163;
            5'd23:   v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/rpe_cordic.sv
// Pipelined turn-based CORDIC: phase in Q0.32 turns to cos/sin in Q1.30.
// Depends on rpe_pkg. The load, each CORDIC stage and the quadrant fold are registered.
module rpe_cordic #(
    parameter int STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [31:0]                        i_phase,
    output logic signed [rpe_pkg::XY_W-1:0]    o_cos,
    output logic signed [rpe_pkg::XY_W-1:0]    o_sin
);

    localparam int N  = (STAGES < rpe_pkg::ATAN_STEPS) ? STAGES : rpe_pkg::ATAN_STEPS;
    localparam int XW = rpe_pkg::XY_W;
    localparam int ZW = rpe_pkg::Z_W;

    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    rpe_pkg::t_quad       r_quad [N+1];
    logic signed [XW-1:0] r_cos;
    logic signed [XW-1:0] r_sin;

    // load: quadrant from the top two bits, residual below
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= rpe_pkg::GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= ZW'({1'b0, i_phase[29:0]});
            r_quad[0] <= rpe_pkg::t_quad'(i_phase[31:30]);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        logic signed [ZW-1:0] w_atan;

        assign w_dx   = r_y[k] >>> k;
        assign w_dy   = r_x[k] >>> k;
        assign w_atan = rpe_pkg::atan_turn(5'(k));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - w_dx;
                    r_y[k+1] <= r_y[k] + w_dy;
                    r_z[k+1] <= r_z[k] - w_atan;
                end else begin
                    r_x[k+1] <= r_x[k] + w_dx;
                    r_y[k+1] <= r_y[k] - w_dy;
                    r_z[k+1] <= r_z[k] + w_atan;
                end
                r_quad[k+1] <= r_quad[k];
            end
        end
    end

    // quadrant fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_quad[N])
                rpe_pkg::QUAD_0: begin
                    r_cos <= r_x[N];
                    r_sin <= r_y[N];
                end
                rpe_pkg::QUAD_1: begin
                    r_cos <= -r_y[N];
                    r_sin <= r_x[N];
                end
                rpe_pkg::QUAD_2: begin
                    r_cos <= -r_x[N];
                    r_sin <= -r_y[N];
                end
                default: begin
                    r_cos <= r_y[N];
                    r_sin <= -r_x[N];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> hdl/rotary_position_embedding_core.sv
// Rotary position embedding core, half-split pairing: table load and pair rotation.
// Depends on rpe_pkg, rpe_cordic and rotary_position_embedding_core_macros.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | to core   | i_valid / o_ready   | op, pair_index, position, values, freq, last
//   out     | from core | o_valid / i_ready   | rotated_first/second, saturated, last_out
//
// One transfer per cycle is taken in unless the output register holds an untaken result; a
// table write uses one slot and yields no result. From input transfer to result the data
// passes the table read, the phase multiply, the CORDIC pipeline, the product and sum stages
// and the output register. The table is one synchronous RAM: one write and one read per cycle.
// Reset clears the pipeline valid bits only; table entries are undefined until written.
// o_ready is held low while reset is asserted.
// While the output register holds an untaken result the whole pipeline freezes.
`include "rotary_position_embedding_core_macros.svh"

module rotary_position_embedding_core #(
    parameter int MAX_PAIRS     = 64,
    parameter int DATA_WIDTH    = 16,
    parameter int PHASE_BITS    = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [rpe_pkg::INDEX_W-1:0]         i_pair_index,
    input  logic [rpe_pkg::POS_W-1:0]           i_position,
    input  logic signed [DATA_WIDTH-1:0]        i_first_value,
    input  logic signed [DATA_WIDTH-1:0]        i_second_value,
    input  logic [rpe_pkg::FREQ_W-1:0]          i_freq_word,
    input  logic                                i_last_pair,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [DATA_WIDTH-1:0]        o_rotated_first,
    output logic signed [DATA_WIDTH-1:0]        o_rotated_second,
    output logic                                o_saturated,
    output logic                                o_last_out
);

    localparam int DW   = DATA_WIDTH;
    localparam int AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int N    = (CORDIC_STAGES < rpe_pkg::ATAN_STEPS) ?
                          CORDIC_STAGES : rpe_pkg::ATAN_STEPS;
    localparam int LAT  = N + 2;                    // CORDIC latency
    localparam int XW   = rpe_pkg::XY_W;
    localparam int PW   = DW + XW;                  // product width
    localparam int SW   = PW + 1;                   // sum width
    localparam int RW   = SW + 1 - 30;              // rounded width
    localparam logic [31:0] PHASE_KEEP = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (DW - 1)));

    logic w_en;
    logic w_accept;
    logic w_wr_xfer;
    logic w_rot_xfer;
    logic w_idx_ok;
    logic [AW-1:0] w_addr;

    // frequency table
    logic [rpe_pkg::FREQ_W-1:0] r_freq_mem [MAX_PAIRS];

    // stage 1: table read
    logic                          r_v1;
    logic                          r_ok1;
    logic [rpe_pkg::FREQ_W-1:0]    r_freq1;
    logic [rpe_pkg::POS_W-1:0]     r_pos1;
    logic signed [DW-1:0]          r_a1, r_b1;
    logic                          r_l1;

    // stage 2: phase
    logic                          r_v2;
    logic [31:0]                   r_phase2;
    logic signed [DW-1:0]          r_a2, r_b2;
    logic                          r_l2;
    logic [rpe_pkg::FREQ_W-1:0]    w_freq_eff;
    logic [47:0]                   w_prod_phase;

    // side data alongside the CORDIC
    logic                          r_dv [LAT];
    logic signed [DW-1:0]          r_da [LAT];
    logic signed [DW-1:0]          r_db [LAT];
    logic                          r_dl [LAT];
    logic signed [XW-1:0]          w_cos, w_sin;

    // products
    logic                          r_vm, r_lm;
    logic signed [PW-1:0]          r_p0, r_p1, r_p2, r_p3;
    logic signed [PW-1:0]          w_a_ext, w_b_ext, w_c_ext, w_s_ext;

    // sums
    logic                          r_vs, r_ls;
    logic signed [SW-1:0]          r_s0, r_s1;
    logic signed [SW:0]            w_rnd0, w_rnd1;
    logic signed [RW-1:0]          w_r0, w_r1;

    // output register
    logic                          r_out_valid;
    logic signed [DW-1:0]          r_out_first, r_out_second;
    logic                          r_out_sat, r_out_last;
    logic signed [DW-1:0]          n_out_first, n_out_second;
    logic                          n_out_sat;

    // pipeline advances unless a result waits at the output
    assign w_en       = !r_out_valid || i_ready;
    assign o_ready    = w_en && i_rst_n;
    assign w_accept   = i_valid && o_ready;
    assign w_wr_xfer  = w_accept && (i_op == rpe_pkg::OP_WRITE);
    assign w_rot_xfer = w_accept && (i_op == rpe_pkg::OP_ROTATE);
    assign w_idx_ok   = (32'(i_pair_index) < 32'(MAX_PAIRS));
    assign w_addr     = AW'(i_pair_index);

    always_ff @(posedge i_clk) begin
        if (w_wr_xfer && w_idx_ok) begin
            r_freq_mem[w_addr] <= i_freq_word;
        end
    end

    // write-then-read of one entry lands in separate cycles, so no bypass
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_freq1 <= r_freq_mem[w_addr];
            r_ok1   <= w_idx_ok;
            r_pos1  <= i_position;
            r_a1    <= i_first_value;
            r_b1    <= i_second_value;
            r_l1    <= i_last_pair;
        end
    end

    // out-of-range index rotates with frequency zero
    assign w_freq_eff   = r_ok1 ? r_freq1 : '0;
    assign w_prod_phase = 48'(r_pos1) * 48'(w_freq_eff);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phase2 <= w_prod_phase[31:0] & PHASE_KEEP;
            r_a2     <= r_a1;
            r_b2     <= r_b1;
            r_l2     <= r_l1;
        end
    end

    rpe_cordic #(
        .STAGES (N)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_phase2),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_da[0] <= r_a2;
            r_db[0] <= r_b2;
            r_dl[0] <= r_l2;
            for (int k = 1; k < LAT; k++) begin
                r_da[k] <= r_da[k-1];
                r_db[k] <= r_db[k-1];
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    assign w_a_ext = PW'(r_da[LAT-1]);
    assign w_b_ext = PW'(r_db[LAT-1]);
    assign w_c_ext = PW'(w_cos);
    assign w_s_ext = PW'(w_sin);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0 <= PW'(w_a_ext * w_c_ext);
            r_p1 <= PW'(w_b_ext * w_s_ext);
            r_p2 <= PW'(w_b_ext * w_c_ext);
            r_p3 <= PW'(w_a_ext * w_s_ext);
            r_lm <= r_dl[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= SW'(r_p0) - SW'(r_p1);
            r_s1 <= SW'(r_p2) + SW'(r_p3);
            r_ls <= r_lm;
        end
    end

    // round half up, floor shift, then clip to the data range
    assign w_rnd0 = (SW + 1)'(r_s0) + (SW + 1)'(rpe_pkg::HALF_Q30);
    assign w_rnd1 = (SW + 1)'(r_s1) + (SW + 1)'(rpe_pkg::HALF_Q30);
    assign w_r0   = RW'(w_rnd0 >>> 30);
    assign w_r1   = RW'(w_rnd1 >>> 30);

    always_comb begin
        n_out_sat = 1'b0;
        if (w_r0 > SAT_HI) begin
            n_out_first = DW'(SAT_HI);
            n_out_sat   = 1'b1;
        end else if (w_r0 < SAT_LO) begin
            n_out_first = DW'(SAT_LO);
            n_out_sat   = 1'b1;
        end else begin
            n_out_first = DW'(w_r0);
        end
        if (w_r1 > SAT_HI) begin
            n_out_second = DW'(SAT_HI);
            n_out_sat    = 1'b1;
        end else if (w_r1 < SAT_LO) begin
            n_out_second = DW'(SAT_LO);
            n_out_sat    = 1'b1;
        end else begin
            n_out_second = DW'(w_r1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_first  <= n_out_first;
            r_out_second <= n_out_second;
            r_out_sat    <= n_out_sat;
            r_out_last   <= r_ls;
        end
    end

    // valid bits: only rotate transfers make results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_vm        <= 1'b0;
            r_vs        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1    <= w_rot_xfer;
            r_v2    <= r_v1;
            r_dv[0] <= r_v2;
            for (int k = 1; k < LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_vm        <= r_dv[LAT-1];
            r_vs        <= r_vm;
            r_out_valid <= r_vs;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_rotated_first  = r_out_first;
    assign o_rotated_second = r_out_second;
    assign o_saturated      = r_out_sat;
    assign o_last_out       = r_out_last;

    // checks
    `RPE_ASSERT_NOW(a_stall_freezes, i_clk, i_rst_n, r_out_valid && !i_ready, !o_ready)
    `RPE_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, w_wr_xfer, !r_v1)
    `RPE_ASSERT_NEXT(a_rotate_enters, i_clk, i_rst_n, w_rot_xfer, r_v1)
    `RPE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_rotated_first))

endmodule

>>> test/rotary_position_embedding_core_tb.sv
// Self-checking testbench for rotary_position_embedding_core: loads the frequency table,
// rotates pairs and compares every result against a cycle-free CORDIC predictor.
// Depends on rpe_pkg and the core RTL.
module rotary_position_embedding_core_tb;

    localparam int MAX_PAIRS     = 64;
    localparam int DATA_WIDTH    = 16;
    localparam int PHASE_BITS    = 32;
    localparam int CORDIC_STAGES = 16;

    localparam int INDEX_W    = rpe_pkg::INDEX_W;
    localparam int POS_W      = rpe_pkg::POS_W;
    localparam int FREQ_W     = rpe_pkg::FREQ_W;
    localparam int ATAN_STEPS = rpe_pkg::ATAN_STEPS;

    localparam int PIPE_LATENCY  = CORDIC_STAGES + 7;
    localparam int DRAIN_CYCLES  = PIPE_LATENCY + 10;
    // longest legal quiet stretch is the longest sender gap, the pipe and the longest
    // receiver stall; this is many times that
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [31:0] PHASE_KEEP = 32'hFFFF_FFFF << (32 - PHASE_BITS);
    localparam longint SAMPLE_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] first;
        logic signed [DATA_WIDTH-1:0] second;
        logic                         sat;
        logic                         last;
    } t_rotation;

    // DUT ports
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic                          o_ready;
    logic                          i_op           = rpe_pkg::OP_WRITE;
    logic [INDEX_W-1:0]            i_pair_index   = '0;
    logic [POS_W-1:0]              i_position     = '0;
    logic signed [DATA_WIDTH-1:0]  i_first_value  = '0;
    logic signed [DATA_WIDTH-1:0]  i_second_value = '0;
    logic [FREQ_W-1:0]             i_freq_word    = '0;
    logic                          i_last_pair    = 1'b0;
    logic                          o_valid;
    logic                          i_ready        = 1'b0;
    logic signed [DATA_WIDTH-1:0]  o_rotated_first;
    logic signed [DATA_WIDTH-1:0]  o_rotated_second;
    logic                          o_saturated;
    logic                          o_last_out;

    // predictor state: shadow of the frequency table and the arctangent steps (Q0.32 turns)
    logic [FREQ_W-1:0] freq_shadow [MAX_PAIRS];
    longint arctan_turns [ATAN_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    t_rotation expected_rotations [$];
    t_rotation exp_rot;

    int  error_count       = 0;
    int  writes_sent       = 0;
    int  rotations_sent    = 0;
    int  rotations_checked = 0;
    int  saturations_seen  = 0;
    int  idle_cycles       = 0;
    int  ready_hold        = 0;
    int  ready_roll;
    bit  full_rate         = 1'b0;  // no gaps and no stalls while set
    logic [INDEX_W-1:0] last_written_index = '0;

    rotary_position_embedding_core #(
        .MAX_PAIRS    (MAX_PAIRS),
        .DATA_WIDTH   (DATA_WIDTH),
        .PHASE_BITS   (PHASE_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_pair_index    (i_pair_index),
        .i_position      (i_position),
        .i_first_value   (i_first_value),
        .i_second_value  (i_second_value),
        .i_freq_word     (i_freq_word),
        .i_last_pair     (i_last_pair),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_rotated_first (o_rotated_first),
        .o_rotated_second(o_rotated_second),
        .o_saturated     (o_saturated),
        .o_last_out      (o_last_out)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // round half up at bit 30, then clip to the sample range
    function automatic logic signed [DATA_WIDTH-1:0] round_clip(input longint acc,
                                                                inout bit clipped);
        longint r;
        r = (acc + longint'(rpe_pkg::HALF_Q30)) >>> 30;
        if (r > SAMPLE_MAX) begin
            clipped = 1'b1;
            r = SAMPLE_MAX;
        end else if (r < SAMPLE_MIN) begin
            clipped = 1'b1;
            r = SAMPLE_MIN;
        end
        return r[DATA_WIDTH-1:0];
    endfunction

    // phase = low 32 bits of position * entry; CORDIC on the quarter-turn residual,
    // then the quadrant picks signs and swaps x/y
    function automatic t_rotation predict_rotation(input logic [INDEX_W-1:0] idx,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_WIDTH-1:0] a,
                                                   input logic signed [DATA_WIDTH-1:0] b,
                                                   input logic last);
        logic [47:0] turns_full;
        logic [31:0] phase;
        longint x, y, z, dx, dy, c, s;
        bit clipped;
        t_rotation res;
        turns_full = 48'(pos) * 48'(freq_shadow[idx]);
        phase = turns_full[31:0] & PHASE_KEEP;
        z = longint'(phase[29:0]);
        x = longint'(rpe_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turns[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turns[i];
            end
        end
        case (rpe_pkg::t_quad'(phase[31:30]))
            rpe_pkg::QUAD_0: begin
                c = x;
                s = y;
            end
            rpe_pkg::QUAD_1: begin
                c = -y;
                s = x;
            end
            rpe_pkg::QUAD_2: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
        clipped    = 1'b0;
        res.first  = round_clip(longint'(a) * c - longint'(b) * s, clipped);
        res.second = round_clip(longint'(b) * c + longint'(a) * s, clipped);
        res.sat    = clipped;
        res.last   = last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (full_rate)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        if (r < 20)
            return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        if (r < 25)
            return '0;
        return DATA_WIDTH'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return POS_W'($urandom_range(0, 65535));
    endfunction

    // Sits at a rising edge on entry and on return; the return edge is the one at
    // which the transfer happened. Valid is only lowered when a gap follows.
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [POS_W-1:0] pos, input logic [DATA_WIDTH-1:0] a,
                             input logic [DATA_WIDTH-1:0] b, input logic [FREQ_W-1:0] freq,
                             input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_pair_index   <= idx;
        i_position     <= pos;
        i_first_value  <= a;
        i_second_value <= b;
        i_freq_word    <= freq;
        i_last_pair    <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (op == rpe_pkg::OP_WRITE) begin
            freq_shadow[idx]   = freq;
            last_written_index = idx;
            writes_sent++;
        end else begin
            expected_rotations.push_back(predict_rotation(idx, pos, a, b, last));
            rotations_sent++;
        end
    endtask

    // random item; a rotate sometimes reuses the entry just written to hit the
    // write-then-read path through the table
    task automatic send_random_item(input int write_pct);
        logic [INDEX_W-1:0] idx;
        logic [FREQ_W-1:0]  freq;
        idx = INDEX_W'($urandom_range(0, MAX_PAIRS - 1));
        if ($urandom_range(0, 99) < write_pct) begin
            freq = $urandom;
            if ($urandom_range(0, 1) == 0)
                freq = freq >> $urandom_range(0, 24);
            send_item(rpe_pkg::OP_WRITE, idx, POS_W'($urandom), DATA_WIDTH'($urandom),
                      DATA_WIDTH'($urandom), freq, 1'($urandom_range(0, 1)));
        end else begin
            if ($urandom_range(0, 99) < 30)
                idx = last_written_index;
            send_item(rpe_pkg::OP_ROTATE, idx, pick_position(), pick_sample(),
                      pick_sample(), $urandom, ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d, t=%0t)",
                 what, got, want, rotations_checked, $time);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every entry written once so no rotate ever reads an unwritten entry
    task automatic test_load_table();
        for (int i = 0; i < MAX_PAIRS; i++)
            send_item(rpe_pkg::OP_WRITE, INDEX_W'(i), POS_W'($urandom),
                      DATA_WIDTH'($urandom), DATA_WIDTH'($urandom), $urandom, 1'b0);
    endtask

    task automatic test_directed();
        // special entries; value and last fields on a write carry junk and must be ignored
        send_item(rpe_pkg::OP_WRITE, 6'd0, '1, '1, '1, 32'h0000_0000, 1'b1);
        send_item(rpe_pkg::OP_WRITE, 6'd1, '0, 16'h8000, 16'h7FFF, 32'h4000_0000, 1'b1);
        send_item(rpe_pkg::OP_WRITE, 6'd2, 16'h1234, 16'h5A5A, 16'hA5A5, 32'h8000_0000, 1'b0);
        send_item(rpe_pkg::OP_WRITE, 6'd3, '1, '0, '0, 32'hFFFF_FFFF, 1'b1);
        send_item(rpe_pkg::OP_WRITE, 6'd4, '0, '1, '0, 32'h2000_0000, 1'b0);
        send_item(rpe_pkg::OP_WRITE, 6'd63, '1, '1, '1, $urandom, 1'b1);
        // phase zero at the largest position: identity rotation
        send_item(rpe_pkg::OP_ROTATE, 6'd0, '1, 16'h7FFF, 16'h8000, 32'd0, 1'b1);
        // all four quadrants, quarter turn per position
        for (int p = 0; p < 4; p++)
            send_item(rpe_pkg::OP_ROTATE, 6'd1, POS_W'(p), 16'sd12345, -16'sd2222,
                      32'd0, 1'b0);
        // eighth turn with full-scale inputs clips
        send_item(rpe_pkg::OP_ROTATE, 6'd4, 16'd1, 16'h7FFF, 16'h7FFF, '1, 1'b1);
        send_item(rpe_pkg::OP_ROTATE, 6'd4, 16'd1, 16'h8000, 16'h8000, '1, 1'b0);
        // half turn negates: -(-32768) clips
        send_item(rpe_pkg::OP_ROTATE, 6'd2, 16'd1, 16'h8000, 16'h0000, 32'd0, 1'b0);
        // all-ones entry times all-ones position
        send_item(rpe_pkg::OP_ROTATE, 6'd3, '1, 16'h8000, 16'h7FFF, 32'd0, 1'b1);
        send_item(rpe_pkg::OP_ROTATE, 6'd63, '1, DATA_WIDTH'($urandom),
                  DATA_WIDTH'($urandom), '0, 1'b0);
        // write followed at once by a rotate of the same entry
        full_rate = 1'b1;
        send_item(rpe_pkg::OP_WRITE, 6'd5, '0, '0, '0, 32'h1555_5555, 1'b0);
        send_item(rpe_pkg::OP_ROTATE, 6'd5, 16'd3, 16'sd4096, 16'sd2048, 32'd0, 1'b1);
        send_item(rpe_pkg::OP_WRITE, 6'd5, '0, '0, '0, 32'h0000_0001, 1'b0);
        send_item(rpe_pkg::OP_ROTATE, 6'd5, '1, 16'sd4096, -16'sd4096, 32'd0, 1'b0);
        full_rate = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 900; n++)
            send_random_item(15);
    endtask

    // one input transfer per cycle with the receiver always ready, heavier on table updates
    task automatic test_full_rate();
        full_rate = 1'b1;
        for (int n = 0; n < 200; n++)
            send_random_item(30);
        full_rate = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready with random stalls, mostly short
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (full_rate) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                ready_hold = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_rotations.size() == 0) begin
                report_mismatch("result with nothing expected", longint'(o_rotated_first), 0);
            end else begin
                exp_rot = expected_rotations.pop_front();
                if (o_rotated_first !== exp_rot.first)
                    report_mismatch("rotated_first", longint'(o_rotated_first),
                                    longint'(exp_rot.first));
                if (o_rotated_second !== exp_rot.second)
                    report_mismatch("rotated_second", longint'(o_rotated_second),
                                    longint'(exp_rot.second));
                if (o_saturated !== exp_rot.sat)
                    report_mismatch("saturated", longint'(o_saturated), longint'(exp_rot.sat));
                if (o_last_out !== exp_rot.last)
                    report_mismatch("last_out", longint'(o_last_out), longint'(exp_rot.last));
                if (exp_rot.sat)
                    saturations_seen++;
                rotations_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_rotations.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_load_table();
        test_directed();
        test_random_traffic();
        test_full_rate();
        i_valid <= 1'b0;
        // drain, then give the pipe time to show any stray result
        while (expected_rotations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d table writes and %0d rotations under random gaps, stalls and",
                 writes_sent, rotations_sent);
        $display("full-rate bursts; %0d results checked, %0d of them clipped.",
                 rotations_checked, saturations_seen);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rpe_pkg.sv
hdl/rpe_cordic.sv
hdl/rotary_position_embedding_core.sv
test/rotary_position_embedding_core_tb.sv
